[sv/rv32i_execute_alu_macros.svh]
// ---------------------------------------------------------------------------
// rv32i_execute_alu_macros.svh
// Assertion macros shared by the execute ALU RTL.
// ---------------------------------------------------------------------------
`ifndef RV32I_EXECUTE_ALU_MACROS_SVH
`define RV32I_EXECUTE_ALU_MACROS_SVH

// Same-cycle implication, off while reset is high
`define RV32EA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rv32ea: same-cycle check failed");

// Next-cycle implication, off while reset is high
`define RV32EA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rv32ea: next-cycle check failed");

`endif

[sv/rv32ea_pkg.sv]
// ---------------------------------------------------------------------------
// rv32ea_pkg
// Types and constants shared by the execute ALU pipeline stages.
// ---------------------------------------------------------------------------
package rv32ea_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned SHAMT_BITS = 5;

  localparam logic [XLEN-1:0] JALR_MASK = 32'hffff_fffe;
  localparam logic [XLEN-1:0] NOT_TAKEN = 32'd4;

  // Operation codes carried in the mode field
  typedef enum logic [4:0] {
    MODE_ADD       = 5'd0,
    MODE_ADDI      = 5'd1,
    MODE_SUB       = 5'd2,
    MODE_LUI       = 5'd3,
    MODE_XOR       = 5'd4,
    MODE_XORI      = 5'd5,
    MODE_AND       = 5'd6,
    MODE_ANDI      = 5'd7,
    MODE_OR        = 5'd8,
    MODE_ORI       = 5'd9,
    MODE_SLL       = 5'd10,
    MODE_SLLI      = 5'd11,
    MODE_SRL       = 5'd12,
    MODE_SRLI      = 5'd13,
    MODE_SRA       = 5'd14,
    MODE_SRAI      = 5'd15,
    MODE_SLT       = 5'd16,
    MODE_SLTU      = 5'd17,
    MODE_SLTI      = 5'd18,
    MODE_SLTIU     = 5'd19,
    MODE_BEQ       = 5'd20,
    MODE_BNE       = 5'd21,
    MODE_BLT       = 5'd22,
    MODE_BGE       = 5'd23,
    MODE_BLTU      = 5'd24,
    MODE_BGEU      = 5'd25,
    MODE_JALR      = 5'd26,
    MODE_MEMADDR   = 5'd27,
    MODE_STOREDATA = 5'd28
  } mode_t;

  // Internal function class after decode
  typedef enum logic [4:0] {
    FN_ADD,
    FN_SUB,
    FN_XOR,
    FN_AND,
    FN_OR,
    FN_SLL,
    FN_SRL,
    FN_SRA,
    FN_SLT,
    FN_SLTU,
    FN_BEQ,
    FN_BNE,
    FN_BLT,
    FN_BGE,
    FN_BLTU,
    FN_BGEU,
    FN_JALR,
    FN_PASS,
    FN_BAD
  } func_t;

  // Input item
  typedef struct packed {
    logic [4:0]             mode;
    logic [XLEN-1:0]        src_one;
    logic [XLEN-1:0]        src_two;
    logic signed [XLEN-1:0] immediate;
    logic [XLEN-1:0]        upper_immediate;
  } op_t;

  // Result item
  typedef struct packed {
    logic [XLEN-1:0] result;
    logic            invalid;
  } res_t;

  // Decode stage to compute stage
  typedef struct packed {
    func_t                 func;
    logic [XLEN-1:0]       opa;
    logic [XLEN-1:0]       opb;
    logic [XLEN-1:0]       offset;
    logic [SHAMT_BITS-1:0] shamt;
  } dec_t;

  // Compute stage to select stage
  typedef struct packed {
    func_t           func;
    logic [XLEN-1:0] value;
    logic [XLEN-1:0] offset;
    logic            lts;
    logic            ltu;
    logic            eq;
  } cmp_t;

endpackage

[sv/rv32i_execute_alu.sv]
// ---------------------------------------------------------------------------
// rv32i_execute_alu
// Three-stage pipelined execute ALU for a 32-bit RISC-V integer core.
// ---------------------------------------------------------------------------
// Usage:
//   The op channel (op_valid/op_ready/op) carries one operation per item:
//   mode, both source register values, the sign-extended immediate and the
//   shifted upper immediate. The res channel (res_valid/res_ready/res)
//   returns one item per operation: the 32-bit result and an invalid flag,
//   set with a zero result for modes 29 to 31.
//   res_valid rises once an accepted item has passed through the stages:
//   decode, compute (adder, comparator, shifter) and select
//   (branch/jump resolution), each ending in a register.
//   Throughput is one item per cycle while res_ready stays high; each stage
//   takes a new item whenever it is empty or its content moves on.
//   When the receiver holds res_ready low the stages fill up behind the
//   output register; op_ready falls once all three stages hold an item and
//   nothing is lost or repeated. Results leave in acceptance order.
//   Reset (rst, synchronous) empties the pipeline; op_ready is high in the
//   first cycle after reset.
// ---------------------------------------------------------------------------
`include "rv32i_execute_alu_macros.svh"

module rv32i_execute_alu (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_ready,
  input  rv32ea_pkg::op_t   op,
  output logic              res_valid,
  input  logic              res_ready,
  output rv32ea_pkg::res_t  res
);

  logic             dec_valid;
  logic             dec_ready;
  rv32ea_pkg::dec_t dec_data;
  logic             cmp_valid;
  logic             cmp_ready;
  rv32ea_pkg::cmp_t cmp_data;

  // Decode stage
  rv32ea_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .up_valid (op_valid),
    .up_ready (op_ready),
    .up_data  (op),
    .dn_valid (dec_valid),
    .dn_ready (dec_ready),
    .dn_data  (dec_data)
  );

  // Compute stage
  rv32ea_compute u_compute (
    .clk      (clk),
    .rst      (rst),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (cmp_valid),
    .dn_ready (cmp_ready),
    .dn_data  (cmp_data)
  );

  // Select stage and output register
  rv32ea_select u_select (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cmp_valid),
    .up_ready (cmp_ready),
    .up_data  (cmp_data),
    .dn_valid (res_valid),
    .dn_ready (res_ready),
    .dn_data  (res)
  );

  // A bad operation always leaves with a zero result
  `RV32EA_ASSERT_NOW(a_invalid_zero, clk, rst, res_valid && res.invalid, res.result == '0)
  // A decoded item moves into the compute stage when that stage can take it
  `RV32EA_ASSERT_NEXT(a_dec_advance, clk, rst, dec_valid && dec_ready, cmp_valid)
  // A full pipeline with a stalled receiver refuses new items
  `RV32EA_ASSERT_NOW(a_full_stall, clk, rst,
                     dec_valid && cmp_valid && res_valid && !res_ready, !op_ready)

endmodule

[sv/rv32ea_decode.sv]
// ---------------------------------------------------------------------------
// rv32ea_decode
// First stage: map the mode onto a function class and pick the operands.
// ---------------------------------------------------------------------------
module rv32ea_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  rv32ea_pkg::op_t   up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output rv32ea_pkg::dec_t  dn_data
);

  rv32ea_pkg::dec_t dec_next;
  logic [rv32ea_pkg::XLEN-1:0] imm_bits;

  assign imm_bits = rv32ea_pkg::XLEN'(unsigned'(up_data.immediate));

  // Stage takes an item when empty or when it drains this cycle
  assign up_ready = !dn_valid || dn_ready;

  // Decode the operation
  always_comb begin
    dec_next.func   = rv32ea_pkg::FN_BAD;
    dec_next.opa    = up_data.src_one;
    dec_next.opb    = up_data.src_two;
    dec_next.offset = imm_bits;
    dec_next.shamt  = up_data.src_two[rv32ea_pkg::SHAMT_BITS-1:0];
    case (up_data.mode)
      rv32ea_pkg::MODE_ADD:   dec_next.func = rv32ea_pkg::FN_ADD;
      rv32ea_pkg::MODE_ADDI: begin
        dec_next.func = rv32ea_pkg::FN_ADD;
        dec_next.opb  = imm_bits;
      end
      rv32ea_pkg::MODE_SUB:   dec_next.func = rv32ea_pkg::FN_SUB;
      rv32ea_pkg::MODE_LUI: begin
        dec_next.func = rv32ea_pkg::FN_PASS;
        dec_next.opb  = up_data.upper_immediate;
      end
      rv32ea_pkg::MODE_XOR:   dec_next.func = rv32ea_pkg::FN_XOR;
      rv32ea_pkg::MODE_XORI: begin
        dec_next.func = rv32ea_pkg::FN_XOR;
        dec_next.opb  = imm_bits;
      end
      rv32ea_pkg::MODE_AND:   dec_next.func = rv32ea_pkg::FN_AND;
      rv32ea_pkg::MODE_ANDI: begin
        dec_next.func = rv32ea_pkg::FN_AND;
        dec_next.opb  = imm_bits;
      end
      rv32ea_pkg::MODE_OR:    dec_next.func = rv32ea_pkg::FN_OR;
      rv32ea_pkg::MODE_ORI: begin
        dec_next.func = rv32ea_pkg::FN_OR;
        dec_next.opb  = imm_bits;
      end
      rv32ea_pkg::MODE_SLL:   dec_next.func = rv32ea_pkg::FN_SLL;
      rv32ea_pkg::MODE_SLLI: begin
        dec_next.func  = rv32ea_pkg::FN_SLL;
        dec_next.shamt = imm_bits[rv32ea_pkg::SHAMT_BITS-1:0];
      end
      rv32ea_pkg::MODE_SRL:   dec_next.func = rv32ea_pkg::FN_SRL;
      rv32ea_pkg::MODE_SRLI: begin
        dec_next.func  = rv32ea_pkg::FN_SRL;
        dec_next.shamt = imm_bits[rv32ea_pkg::SHAMT_BITS-1:0];
      end
      rv32ea_pkg::MODE_SRA:   dec_next.func = rv32ea_pkg::FN_SRA;
      rv32ea_pkg::MODE_SRAI: begin
        dec_next.func  = rv32ea_pkg::FN_SRA;
        dec_next.shamt = imm_bits[rv32ea_pkg::SHAMT_BITS-1:0];
      end
      rv32ea_pkg::MODE_SLT:   dec_next.func = rv32ea_pkg::FN_SLT;
      rv32ea_pkg::MODE_SLTU:  dec_next.func = rv32ea_pkg::FN_SLTU;
      rv32ea_pkg::MODE_SLTI: begin
        dec_next.func = rv32ea_pkg::FN_SLT;
        dec_next.opb  = imm_bits;
      end
      rv32ea_pkg::MODE_SLTIU: begin
        dec_next.func = rv32ea_pkg::FN_SLTU;
        dec_next.opb  = imm_bits;
      end
      rv32ea_pkg::MODE_BEQ:   dec_next.func = rv32ea_pkg::FN_BEQ;
      rv32ea_pkg::MODE_BNE:   dec_next.func = rv32ea_pkg::FN_BNE;
      rv32ea_pkg::MODE_BLT:   dec_next.func = rv32ea_pkg::FN_BLT;
      rv32ea_pkg::MODE_BGE:   dec_next.func = rv32ea_pkg::FN_BGE;
      rv32ea_pkg::MODE_BLTU:  dec_next.func = rv32ea_pkg::FN_BLTU;
      rv32ea_pkg::MODE_BGEU:  dec_next.func = rv32ea_pkg::FN_BGEU;
      rv32ea_pkg::MODE_JALR: begin
        dec_next.func = rv32ea_pkg::FN_JALR;
        dec_next.opb  = imm_bits;
      end
      rv32ea_pkg::MODE_MEMADDR: begin
        dec_next.func = rv32ea_pkg::FN_ADD;
        dec_next.opb  = imm_bits;
      end
      rv32ea_pkg::MODE_STOREDATA: dec_next.func = rv32ea_pkg::FN_PASS;
      default:                    dec_next.func = rv32ea_pkg::FN_BAD;
    endcase
  end

  // Hold or advance the stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_data <= dec_next;
    end
  end

endmodule

[sv/rv32ea_compute.sv]
// ---------------------------------------------------------------------------
// rv32ea_compute
// Second stage: adder, subtractor/comparator, logic unit and shifter.
// ---------------------------------------------------------------------------
module rv32ea_compute (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  rv32ea_pkg::dec_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output rv32ea_pkg::cmp_t  dn_data
);

  localparam int unsigned W = rv32ea_pkg::XLEN;

  rv32ea_pkg::cmp_t cmp_next;
  logic [W-1:0]     sum;
  logic [W:0]       diff;

  assign up_ready = !dn_valid || dn_ready;

  // Shared add and compare paths
  assign sum  = up_data.opa + up_data.opb;
  assign diff = {1'b0, up_data.opa} - {1'b0, up_data.opb};

  always_comb begin
    cmp_next.func   = up_data.func;
    cmp_next.offset = up_data.offset;
    cmp_next.eq     = (up_data.opa == up_data.opb);
    cmp_next.ltu    = diff[W];
    // Signs differ: the negative one is smaller
    cmp_next.lts    = (up_data.opa[W-1] != up_data.opb[W-1]) ? up_data.opa[W-1] : diff[W];
    case (up_data.func)
      rv32ea_pkg::FN_ADD:  cmp_next.value = sum;
      rv32ea_pkg::FN_JALR: cmp_next.value = sum;
      rv32ea_pkg::FN_SUB:  cmp_next.value = diff[W-1:0];
      rv32ea_pkg::FN_XOR:  cmp_next.value = up_data.opa ^ up_data.opb;
      rv32ea_pkg::FN_AND:  cmp_next.value = up_data.opa & up_data.opb;
      rv32ea_pkg::FN_OR:   cmp_next.value = up_data.opa | up_data.opb;
      rv32ea_pkg::FN_SLL:  cmp_next.value = up_data.opa << up_data.shamt;
      rv32ea_pkg::FN_SRL:  cmp_next.value = up_data.opa >> up_data.shamt;
      rv32ea_pkg::FN_SRA:  cmp_next.value = W'($signed(up_data.opa) >>> up_data.shamt);
      rv32ea_pkg::FN_PASS: cmp_next.value = up_data.opb;
      default:             cmp_next.value = '0;
    endcase
  end

  // Hold or advance the stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_data <= cmp_next;
    end
  end

endmodule

[sv/rv32ea_select.sv]
// ---------------------------------------------------------------------------
// rv32ea_select
// Third stage: resolve branches and compares, mask jump targets, flag bad ops.
// ---------------------------------------------------------------------------
module rv32ea_select (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  rv32ea_pkg::cmp_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output rv32ea_pkg::res_t  dn_data
);

  localparam int unsigned W = rv32ea_pkg::XLEN;

  rv32ea_pkg::res_t res_next;
  logic             take;

  assign up_ready = !dn_valid || dn_ready;

  // Branch condition
  always_comb begin
    case (up_data.func)
      rv32ea_pkg::FN_BEQ:  take = up_data.eq;
      rv32ea_pkg::FN_BNE:  take = !up_data.eq;
      rv32ea_pkg::FN_BLT:  take = up_data.lts;
      rv32ea_pkg::FN_BGE:  take = !up_data.lts;
      rv32ea_pkg::FN_BLTU: take = up_data.ltu;
      rv32ea_pkg::FN_BGEU: take = !up_data.ltu;
      default:             take = 1'b0;
    endcase
  end

  // Final result selection
  always_comb begin
    res_next.invalid = 1'b0;
    case (up_data.func)
      rv32ea_pkg::FN_SLT:  res_next.result = W'(up_data.lts);
      rv32ea_pkg::FN_SLTU: res_next.result = W'(up_data.ltu);
      rv32ea_pkg::FN_BEQ,
      rv32ea_pkg::FN_BNE,
      rv32ea_pkg::FN_BLT,
      rv32ea_pkg::FN_BGE,
      rv32ea_pkg::FN_BLTU,
      rv32ea_pkg::FN_BGEU: res_next.result = take ? up_data.offset : rv32ea_pkg::NOT_TAKEN;
      rv32ea_pkg::FN_JALR: res_next.result = up_data.value & rv32ea_pkg::JALR_MASK;
      rv32ea_pkg::FN_BAD: begin
        res_next.result  = '0;
        res_next.invalid = 1'b1;
      end
      default:             res_next.result = up_data.value;
    endcase
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_data <= res_next;
    end
  end

endmodule

[test/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the pipelined RV32I execute ALU. Operations go in
// over the op channel, and a local ALU model predicts each result and invalid
// flag. Every result from the res channel is checked in order against that
// prediction. Traffic runs in phases with different amounts of sender idling
// and receiver stalling, plus a long output hold that fills the pipeline.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted outcome, kept with the operation that caused it
  typedef struct {
    rv32ea_pkg::op_t  item;
    rv32ea_pkg::res_t outcome;
  } alu_outcome_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             op_valid;
  logic             op_ready;
  rv32ea_pkg::op_t  op;
  logic             res_valid;
  logic             res_ready;
  rv32ea_pkg::res_t res;

  alu_outcome_t expected_outcomes[$];
  int           error_count    = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           hold_left      = 0;

  rv32i_execute_alu i_dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #4ns clk = ~clk;

  // Work out the result and invalid flag for one operation
  function automatic rv32ea_pkg::res_t alu_outcome(input rv32ea_pkg::op_t item);
    logic [rv32ea_pkg::XLEN-1:0]       a;
    logic [rv32ea_pkg::XLEN-1:0]       b;
    logic [rv32ea_pkg::XLEN-1:0]       imm;
    logic [rv32ea_pkg::XLEN-1:0]       r;
    logic [rv32ea_pkg::SHAMT_BITS-1:0] sh_reg;
    logic [rv32ea_pkg::SHAMT_BITS-1:0] sh_imm;
    logic                              bad;
    rv32ea_pkg::res_t                  outcome;
    a      = item.src_one;
    b      = item.src_two;
    imm    = item.immediate;
    sh_reg = b[rv32ea_pkg::SHAMT_BITS-1:0];
    sh_imm = imm[rv32ea_pkg::SHAMT_BITS-1:0];
    r      = '0;
    bad    = 1'b0;
    case (item.mode)
      rv32ea_pkg::MODE_ADD:       r = a + b;
      rv32ea_pkg::MODE_ADDI:      r = a + imm;
      rv32ea_pkg::MODE_SUB:       r = a - b;
      rv32ea_pkg::MODE_LUI:       r = item.upper_immediate;
      rv32ea_pkg::MODE_XOR:       r = a ^ b;
      rv32ea_pkg::MODE_XORI:      r = a ^ imm;
      rv32ea_pkg::MODE_AND:       r = a & b;
      rv32ea_pkg::MODE_ANDI:      r = a & imm;
      rv32ea_pkg::MODE_OR:        r = a | b;
      rv32ea_pkg::MODE_ORI:       r = a | imm;
      rv32ea_pkg::MODE_SLL:       r = a << sh_reg;
      rv32ea_pkg::MODE_SLLI:      r = a << sh_imm;
      rv32ea_pkg::MODE_SRL:       r = a >> sh_reg;
      rv32ea_pkg::MODE_SRLI:      r = a >> sh_imm;
      rv32ea_pkg::MODE_SRA:       r = $signed(a) >>> sh_reg;
      rv32ea_pkg::MODE_SRAI:      r = $signed(a) >>> sh_imm;
      rv32ea_pkg::MODE_SLT:       r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      rv32ea_pkg::MODE_SLTU:      r = (a < b) ? 32'd1 : 32'd0;
      rv32ea_pkg::MODE_SLTI:      r = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
      rv32ea_pkg::MODE_SLTIU:     r = (a < imm) ? 32'd1 : 32'd0;
      rv32ea_pkg::MODE_BEQ:       r = (a == b) ? imm : rv32ea_pkg::NOT_TAKEN;
      rv32ea_pkg::MODE_BNE:       r = (a != b) ? imm : rv32ea_pkg::NOT_TAKEN;
      rv32ea_pkg::MODE_BLT:       r = ($signed(a) < $signed(b)) ? imm : rv32ea_pkg::NOT_TAKEN;
      rv32ea_pkg::MODE_BGE:       r = ($signed(a) >= $signed(b)) ? imm : rv32ea_pkg::NOT_TAKEN;
      rv32ea_pkg::MODE_BLTU:      r = (a < b) ? imm : rv32ea_pkg::NOT_TAKEN;
      rv32ea_pkg::MODE_BGEU:      r = (a >= b) ? imm : rv32ea_pkg::NOT_TAKEN;
      rv32ea_pkg::MODE_JALR:      r = (a + imm) & rv32ea_pkg::JALR_MASK;
      rv32ea_pkg::MODE_MEMADDR:   r = a + imm;
      rv32ea_pkg::MODE_STOREDATA: r = b;
      default:                    bad = 1'b1;
    endcase
    outcome.result  = r;
    outcome.invalid = bad;
    return outcome;
  endfunction

  // Favour edge values so compares, shifts and wraps see their corners
  function automatic logic [rv32ea_pkg::XLEN-1:0] pick_word();
    logic [rv32ea_pkg::XLEN-1:0] w;
    w = $urandom();
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = '1;
      2:       w = 32'h8000_0000;
      3:       w = 32'h7fff_ffff;
      4:       w = $urandom_range(31);
      default: ;
    endcase
    return w;
  endfunction

  function automatic rv32ea_pkg::op_t make_random_op();
    rv32ea_pkg::op_t             item;
    logic [rv32ea_pkg::XLEN-1:0] raw;
    if ($urandom_range(99) < 94) begin
      item.mode = 5'($urandom_range(rv32ea_pkg::MODE_STOREDATA));
    end else begin
      item.mode = 5'($urandom_range(31, rv32ea_pkg::MODE_STOREDATA + 1));
    end
    item.src_one = pick_word();
    item.src_two = pick_word();
    raw = $urandom();
    if ($urandom_range(1)) begin
      item.immediate = {{20{raw[11]}}, raw[11:0]};
    end else begin
      item.immediate = pick_word();
    end
    raw = $urandom();
    item.upper_immediate = $urandom_range(3) ? {raw[31:12], 12'h000} : pick_word();
    // force equal operands now and then so branches and compares tie
    if ($urandom_range(3) == 0) begin
      item.src_two = item.src_one;
    end
    if ($urandom_range(7) == 0) begin
      item.immediate = item.src_one;
    end
    return item;
  endfunction

  task automatic report_mismatch(input string what, input rv32ea_pkg::op_t item,
                                 input logic [rv32ea_pkg::XLEN-1:0] got,
                                 input logic [rv32ea_pkg::XLEN-1:0] want);
    $display("mismatch %s: mode %0d a %h b %h imm %h: got %h want %h", what,
             item.mode, item.src_one, item.src_two, item.immediate, got, want);
    error_count++;
  endtask

  // Offer one item, holding valid and payload until it is taken
  task automatic send_op(input rv32ea_pkg::op_t item);
    alu_outcome_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      op_valid <= 1'b0;
      @(posedge clk);
    end
    op_valid <= 1'b1;
    op       <= item;
    do @(posedge clk); while (!op_ready);
    entry.item    = item;
    entry.outcome = alu_outcome(item);
    expected_outcomes.push_back(entry);
  endtask

  // Pause the sender until every predicted result has come back
  task automatic wait_for_drain();
    op_valid <= 1'b0;
    do @(posedge clk); while (expected_outcomes.size() != 0);
  endtask

  task automatic check_result(input rv32ea_pkg::res_t got);
    alu_outcome_t want;
    if (expected_outcomes.size() == 0) begin
      report_mismatch("unexpected item", '0, got.result, '0);
    end else begin
      want = expected_outcomes.pop_front();
      if (got.result !== want.outcome.result) begin
        report_mismatch("result", want.item, got.result, want.outcome.result);
      end
      if (got.invalid !== want.outcome.invalid) begin
        report_mismatch("invalid", want.item, 32'(got.invalid),
                        32'(want.outcome.invalid));
      end
    end
  endtask

  // Take results, stalling at random or through a counted hold-off
  always @(posedge clk) begin
    if (res_valid && res_ready) begin
      check_result(res);
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every operation code once, undefined ones included, with edge operands
  task automatic run_directed_ops();
    rv32ea_pkg::op_t item;
    for (int m = 0; m < 2 ** 5; m++) begin
      item.mode            = 5'(m);
      item.src_one         = 32'h8000_0001;
      item.src_two         = (m % 3 == 2) ? 32'h8000_0001 : 32'hffff_ffff;
      item.immediate       = m[0] ? 32'hffff_f800 : 32'h0000_07ff;
      item.upper_immediate = 32'hffff_f000;
      send_op(item);
    end
    wait_for_drain();
  endtask

  task automatic run_random_traffic(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_op(make_random_op());
    wait_for_drain();
  endtask

  // Hold the output long enough that the pipeline fills and stalls its input
  task automatic run_output_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 40;
    repeat (12) send_op(make_random_op());
    wait_for_drain();
  endtask

  initial begin
    rst       <= 1'b1;
    op_valid  <= 1'b0;
    op        <= '0;
    res_ready <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_directed_ops();
    run_random_traffic(150, 0, 0);
    run_random_traffic(150, 79, 0);
    run_output_hold();
    run_random_traffic(150, 0, 79);
    run_random_traffic(150, 31, 31);
    // let any stray result surface before the verdict
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
